// File: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ESC_ASSERT_IMPL(lbl, clk_s, rstn_s, pre, post) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (pre) |-> (post)) \
        else $error("same-cycle port check failed");

// Next-cycle implication, disabled while reset is low.
`define ESC_ASSERT_NEXT(lbl, clk_s, rstn_s, pre, post) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (pre) |=> (post)) \
        else $error("next-cycle port check failed");

`endif

// File: rtl/esc_pkg.sv
// Shared types and constants of the environmental sensor compensation core.
package esc_pkg;

    localparam int unsigned S_DATA_W   = 56;
    localparam int unsigned M_DATA_W   = 120;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 64;
    localparam int unsigned DIV_STAGES = 64;

    localparam logic [31:0] HUM_MAX    = 32'd419430400;
    localparam logic [63:0] NUM_SCALE  = 64'd3125;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TEMP       = 3'd0,
        REG_PRESS_LO   = 3'd1,
        REG_PRESS_HI   = 3'd2,
        REG_PRESS_NINE = 3'd3,
        REG_HUM_A      = 3'd4,
        REG_HUM_B      = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [47:0] temp;
        logic [63:0] press_lo;
        logic [63:0] press_hi;
        logic [15:0] press_nine;
        logic [31:0] hum_a;
        logic [31:0] hum_b;
    } esc_coef_t;

    // Finished fields carried alongside the pressure divide
    typedef struct packed {
        logic [31:0] tc;
        logic [31:0] tf;
        logic [16:0] hum;
        logic        pvalid;
    } esc_side_t;

    typedef struct packed {
        logic [63:0] num;
        logic [63:0] den;
        esc_side_t   side;
    } esc_div_in_t;

    typedef struct packed {
        logic [63:0] quot;
        logic        neg;
        esc_side_t   side;
    } esc_div_out_t;

    typedef struct packed {
        logic [31:0] tc;
        logic [31:0] tf;
        logic [31:0] press;
        logic        pvalid;
        logic [16:0] hum;
    } esc_result_t;

endpackage

// File: rtl/env_sensor_compensation_core.sv
// Each input transfer passes through the front, divide and post pipelines to the output channel.
// Throughput: one triple per cycle; the pressure divide is 64 one-bit stages plus
// sign handling, and every stage advances together whenever the result register
// is empty or being taken. Reset clears all valid bits and the coefficient
// registers; no clearing pass is needed.
module env_sensor_compensation_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // raw_pressure[19:0], raw_temperature[39:20], raw_humidity[55:40]
    input  logic [esc_pkg::S_DATA_W-1:0]      s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // temperature_centi[31:0], fine_temperature[63:32], pressure_q24_8[95:64],
    // humidity_q22_10[112:96], zero[119:113]
    output logic [esc_pkg::M_DATA_W-1:0]      m_axis_tdata,
    // pressure_valid[0]
    output logic [0:0]                        m_axis_tuser,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [esc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [esc_pkg::CFG_DATA_W-1:0]    cfg_data
);

    esc_pkg::esc_coef_t    coef_reg;
    esc_pkg::esc_div_in_t  div_in;
    esc_pkg::esc_div_out_t div_out;
    esc_pkg::esc_result_t  res;
    logic                  en, front_valid, div_valid, res_valid;

    // Freeze the whole pipeline while a result waits
    assign en            = !res_valid || m_axis_tready;
    assign s_axis_tready = en;
    assign cfg_ready     = 1'b1;

    // Coefficient register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                esc_pkg::REG_TEMP:       coef_reg.temp       <= cfg_data[47:0];
                esc_pkg::REG_PRESS_LO:   coef_reg.press_lo   <= cfg_data;
                esc_pkg::REG_PRESS_HI:   coef_reg.press_hi   <= cfg_data;
                esc_pkg::REG_PRESS_NINE: coef_reg.press_nine <= cfg_data[15:0];
                esc_pkg::REG_HUM_A:      coef_reg.hum_a      <= cfg_data[31:0];
                esc_pkg::REG_HUM_B:      coef_reg.hum_b      <= cfg_data[31:0];
                default:                 ;
            endcase
        end
    end

    esc_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .en              (en),
        .in_valid        (s_axis_tvalid),
        .raw_pressure    (s_axis_tdata[19:0]),
        .raw_temperature (s_axis_tdata[39:20]),
        .raw_humidity    (s_axis_tdata[55:40]),
        .coef            (coef_reg),
        .out_valid       (front_valid),
        .out_data        (div_in)
    );

    esc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (front_valid),
        .in_data   (div_in),
        .out_valid (div_valid),
        .out_data  (div_out)
    );

    esc_post u_post (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (div_valid),
        .in_data   (div_out),
        .coef      (coef_reg),
        .out_valid (res_valid),
        .out_data  (res)
    );

    assign m_axis_tvalid = res_valid;
    assign m_axis_tdata  = {7'b0, res.hum, res.press, res.tf, res.tc};
    assign m_axis_tuser  = res.pvalid;

endmodule

// File: rtl/esc_mul64.sv
// Two-stage 64x64 multiplier keeping the low 64 bits of the product.
module esc_mul64 (
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic [63:0] p
);

    logic [63:0] ll_reg;
    logic [31:0] lh_reg;
    logic [31:0] hl_reg;
    logic [63:0] p_reg;

    // Partial products, then combine the cross terms into the upper half
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ll_reg <= a[31:0] * b[31:0];
            lh_reg <= a[31:0] * b[63:32];
            hl_reg <= a[63:32] * b[31:0];
            p_reg  <= ll_reg + {lh_reg + hl_reg, 32'b0};
        end
    end

    assign p = p_reg;

endmodule

// File: rtl/esc_front.sv
// Temperature and humidity compensation and pressure divide operands.
module esc_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic [19:0]            raw_pressure,
    input  logic [19:0]            raw_temperature,
    input  logic [15:0]            raw_humidity,
    input  esc_pkg::esc_coef_t     coef,
    output logic                   out_valid,
    output esc_pkg::esc_div_in_t   out_data
);

    logic [31:0] t1, t2, t3, h1, h2, h3, h4, h5, h6;
    logic [63:0] p1, p2, p3, p4, p5, p6;

    logic [14:1] vld_reg;
    logic [19:0] adct_reg;
    logic [19:0] adcp_reg [1:11];
    logic [15:0] adch_reg [1:6];
    logic [31:0] d1_reg, d2_reg, m1_reg, m2_reg, ta_reg, m3_reg;
    logic [31:0] tf_reg [5:14];
    logic [31:0] tc_reg [6:14];
    logic [63:0] pv_reg;
    logic [31:0] hv_reg, ha_reg, hb_reg, hc_reg, xb_reg;
    logic [31:0] x_reg [8:11];
    logic [31:0] y1_reg, c2_reg, y2_reg, hm_reg, y3_reg, hs_reg, hk_reg;
    logic [31:0] vv_reg [12:14];
    logic [63:0] vp5_reg [9:10];
    logic [63:0] vp2_reg [9:10];
    logic [63:0] v2_reg, w_reg, w2_reg, n_reg;

    logic [31:0] m1_sra, m2_sra, tb, tc_sum, tc_sra, hb_sra, hc_sra;
    logic [31:0] vv_sra, hs_sra, hk_sra, hr, hum_lim;
    logic [63:0] sq, vp5, vp2, sq6, sq3, sq3_sra, dp, pw, num, den;

    // Coefficient fields
    assign t1 = {16'b0, coef.temp[15:0]};
    assign t2 = {{16{coef.temp[31]}}, coef.temp[31:16]};
    assign t3 = {{16{coef.temp[47]}}, coef.temp[47:32]};
    assign p1 = {48'b0, coef.press_lo[15:0]};
    assign p2 = {{48{coef.press_lo[31]}}, coef.press_lo[31:16]};
    assign p3 = {{48{coef.press_lo[47]}}, coef.press_lo[47:32]};
    assign p4 = {{48{coef.press_lo[63]}}, coef.press_lo[63:48]};
    assign p5 = {{48{coef.press_hi[15]}}, coef.press_hi[15:0]};
    assign p6 = {{48{coef.press_hi[31]}}, coef.press_hi[31:16]};
    assign h1 = {24'b0, coef.hum_a[7:0]};
    assign h2 = {{16{coef.hum_a[23]}}, coef.hum_a[23:8]};
    assign h3 = {24'b0, coef.hum_a[31:24]};
    assign h4 = {{20{coef.hum_b[11]}}, coef.hum_b[11:0]};
    assign h5 = {{20{coef.hum_b[23]}}, coef.hum_b[23:12]};
    assign h6 = {{24{coef.hum_b[31]}}, coef.hum_b[31:24]};

    // Arithmetic right shifts, the scaled temperature sum and the pressure offset
    assign m1_sra  = $signed(m1_reg) >>> 11;
    assign m2_sra  = $signed(m2_reg) >>> 12;
    assign tb      = $signed(m3_reg) >>> 14;
    assign tc_sum  = {tf_reg[5][29:0], 2'b0} + tf_reg[5] + 32'd128;
    assign tc_sra  = $signed(tc_sum) >>> 8;
    assign hb_sra  = $signed(hb_reg) >>> 10;
    assign hc_sra  = $signed(hc_reg) >>> 11;
    assign vv_sra  = $signed(vv_reg[12]) >>> 15;
    assign hs_sra  = $signed(hs_reg) >>> 7;
    assign hk_sra  = $signed(hk_reg) >>> 4;
    assign sq3_sra = $signed(sq3) >>> 8;
    assign den     = $signed(pw) >>> 33;
    assign dp      = 64'd1048576 - {44'b0, adcp_reg[11]};

    // Pressure products
    esc_mul64 u_sq  (.clk(clk), .en(en), .a(pv_reg), .b(pv_reg), .p(sq));
    esc_mul64 u_vp5 (.clk(clk), .en(en), .a(pv_reg), .b(p5),     .p(vp5));
    esc_mul64 u_vp2 (.clk(clk), .en(en), .a(pv_reg), .b(p2),     .p(vp2));
    esc_mul64 u_sq6 (.clk(clk), .en(en), .a(sq),     .b(p6),     .p(sq6));
    esc_mul64 u_sq3 (.clk(clk), .en(en), .a(sq),     .b(p3),     .p(sq3));
    esc_mul64 u_pw  (.clk(clk), .en(en), .a(w2_reg), .b(p1),     .p(pw));
    esc_mul64 u_num (.clk(clk), .en(en), .a(n_reg),  .b(esc_pkg::NUM_SCALE), .p(num));

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[13:1], in_valid};
        end
    end

    // Advance datapath stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // stage 1: capture
            adct_reg    <= raw_temperature;
            adcp_reg[1] <= raw_pressure;
            adch_reg[1] <= raw_humidity;
            for (int i = 2; i <= 11; i++)
            begin
                adcp_reg[i] <= adcp_reg[i-1];
            end
            for (int i = 2; i <= 6; i++)
            begin
                adch_reg[i] <= adch_reg[i-1];
            end
            // stages 2 to 5: temperature
            d1_reg    <= {15'b0, adct_reg[19:3]} - {15'b0, coef.temp[15:0], 1'b0};
            d2_reg    <= {16'b0, adct_reg[19:4]} - t1;
            m1_reg    <= d1_reg * t2;
            m2_reg    <= d2_reg * d2_reg;
            ta_reg    <= m1_sra;
            m3_reg    <= m2_sra * t3;
            tf_reg[5] <= ta_reg + tb;
            for (int i = 6; i <= 14; i++)
            begin
                tf_reg[i] <= tf_reg[i-1];
            end
            // stage 6: scaled temperature and offsets
            tc_reg[6] <= tc_sra;
            for (int i = 7; i <= 14; i++)
            begin
                tc_reg[i] <= tc_reg[i-1];
            end
            pv_reg <= {{32{tf_reg[5][31]}}, tf_reg[5]} - 64'd128000;
            hv_reg <= tf_reg[5] - 32'd76800;
            // stages 7 to 14: humidity
            ha_reg    <= h5 * hv_reg;
            hb_reg    <= hv_reg * h6;
            hc_reg    <= hv_reg * h3;
            xb_reg    <= {2'b0, adch_reg[6], 14'b0} - {h4[11:0], 20'b0} + 32'd16384;
            x_reg[8]  <= $signed(xb_reg - ha_reg) >>> 15;
            for (int i = 9; i <= 11; i++)
            begin
                x_reg[i] <= x_reg[i-1];
            end
            y1_reg     <= hb_sra;
            c2_reg     <= hc_sra + 32'd32768;
            y2_reg     <= $signed(y1_reg * c2_reg) >>> 10;
            hm_reg     <= (y2_reg + 32'd2097152) * h2;
            y3_reg     <= $signed(hm_reg + 32'd8192) >>> 14;
            vv_reg[12] <= x_reg[11] * y3_reg;
            vv_reg[13] <= vv_reg[12];
            vv_reg[14] <= vv_reg[13];
            hs_reg     <= vv_sra * vv_sra;
            hk_reg     <= hs_sra * h1;
            // stages 9 to 12: pressure sums
            vp5_reg[9]  <= vp5;
            vp5_reg[10] <= vp5_reg[9];
            vp2_reg[9]  <= vp2;
            vp2_reg[10] <= vp2_reg[9];
            v2_reg <= sq6 + {vp5_reg[10][46:0], 17'b0} + {p4[28:0], 35'b0};
            w_reg  <= sq3_sra + {vp2_reg[10][51:0], 12'b0};
            w2_reg <= w_reg + 64'h0000_8000_0000_0000;
            n_reg  <= {dp[32:0], 31'b0} - v2_reg;
        end
    end

    // Clamp humidity and scale to Q22.10
    assign hr = vv_reg[14] - hk_sra;
    always_comb
    begin
        if (hr[31])
        begin
            hum_lim = '0;
        end
        else if (hr > esc_pkg::HUM_MAX)
        begin
            hum_lim = esc_pkg::HUM_MAX;
        end
        else
        begin
            hum_lim = hr;
        end
    end

    assign out_valid            = vld_reg[14];
    assign out_data.num         = num;
    assign out_data.den         = den;
    assign out_data.side.tc     = tc_reg[14];
    assign out_data.side.tf     = tf_reg[14];
    assign out_data.side.hum    = hum_lim[28:12];
    assign out_data.side.pvalid = (den != 64'd0);

endmodule

// File: rtl/esc_div.sv
// Pipelined signed 64-bit divider, one quotient bit per stage.
module esc_div (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  esc_pkg::esc_div_in_t  in_data,
    output logic                  out_valid,
    output esc_pkg::esc_div_out_t out_data
);

    typedef struct packed {
        logic [63:0]        rem;
        logic [63:0]        qn;
        logic [63:0]        dv;
        logic               neg;
        esc_pkg::esc_side_t side;
    } div_stage_t;

    div_stage_t                  stg_reg [0:esc_pkg::DIV_STAGES];
    div_stage_t                  stg0_next;
    logic [esc_pkg::DIV_STAGES:0] vld_reg;

    // One restoring step: shift in a numerator bit, subtract when it fits
    function automatic div_stage_t div_step(input div_stage_t s);
        logic [63:0] trial;
        div_stage_t  r;
        r     = s;
        trial = {s.rem[62:0], s.qn[63]};
        if (trial >= s.dv)
        begin
            r.rem = trial - s.dv;
            r.qn  = {s.qn[62:0], 1'b1};
        end
        else
        begin
            r.rem = trial;
            r.qn  = {s.qn[62:0], 1'b0};
        end
        return r;
    endfunction

    // Take magnitudes and note the quotient sign
    always_comb
    begin
        stg0_next.rem  = '0;
        stg0_next.qn   = in_data.num[63] ? 64'd0 - in_data.num : in_data.num;
        stg0_next.dv   = in_data.den[63] ? 64'd0 - in_data.den : in_data.den;
        stg0_next.neg  = in_data.num[63] ^ in_data.den[63];
        stg0_next.side = in_data.side;
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[esc_pkg::DIV_STAGES-1:0], in_valid};
        end
    end

    // Advance divide stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stg_reg[0] <= stg0_next;
            for (int i = 0; i < esc_pkg::DIV_STAGES; i++)
            begin
                stg_reg[i+1] <= div_step(stg_reg[i]);
            end
        end
    end

    assign out_valid     = vld_reg[esc_pkg::DIV_STAGES];
    assign out_data.quot = stg_reg[esc_pkg::DIV_STAGES].qn;
    assign out_data.neg  = stg_reg[esc_pkg::DIV_STAGES].neg;
    assign out_data.side = stg_reg[esc_pkg::DIV_STAGES].side;

endmodule

// File: rtl/esc_post.sv
// Pressure correction terms after the divide, saturation and result register.
module esc_post (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  esc_pkg::esc_div_out_t in_data,
    input  esc_pkg::esc_coef_t    coef,
    output logic                  out_valid,
    output esc_pkg::esc_result_t  out_data
);

    logic [63:0] p7, p8, p9;
    logic [8:1]  vld_reg;
    logic [63:0] p_reg [1:5];
    logic [63:0] p8p_reg [4:5];
    logic [63:0] s_reg, r_reg;
    esc_pkg::esc_side_t   side_reg [1:7];
    esc_pkg::esc_result_t res_reg;
    logic [63:0] pa, aa, p8p, e1, e1_sra, p8p_sra, s_sra;

    assign p7 = {{48{coef.press_hi[47]}}, coef.press_hi[47:32]};
    assign p8 = {{48{coef.press_hi[63]}}, coef.press_hi[63:48]};
    assign p9 = {{48{coef.press_nine[15]}}, coef.press_nine};

    assign pa      = $signed(p_reg[1]) >>> 13;
    assign e1_sra  = $signed(e1) >>> 25;
    assign p8p_sra = $signed(p8p_reg[5]) >>> 19;
    assign s_sra   = $signed(s_reg) >>> 8;

    esc_mul64 u_aa  (.clk(clk), .en(en), .a(pa),       .b(pa), .p(aa));
    esc_mul64 u_p8p (.clk(clk), .en(en), .a(p_reg[1]), .b(p8), .p(p8p));
    esc_mul64 u_e1  (.clk(clk), .en(en), .a(aa),       .b(p9), .p(e1));

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[7:1], in_valid};
        end
    end

    // Advance correction stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg[1]    <= in_data.neg ? 64'd0 - in_data.quot : in_data.quot;
            side_reg[1] <= in_data.side;
            for (int i = 2; i <= 5; i++)
            begin
                p_reg[i] <= p_reg[i-1];
            end
            for (int i = 2; i <= 7; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
            p8p_reg[4] <= p8p;
            p8p_reg[5] <= p8p_reg[4];
            s_reg      <= p_reg[5] + e1_sra + p8p_sra;
            r_reg      <= s_sra + {p7[59:0], 4'b0};
            // Saturate to the unsigned 32-bit range; drop when divisor was zero
            if (!side_reg[7].pvalid || r_reg[63])
            begin
                res_reg.press <= '0;
            end
            else if (r_reg[63:32] != 32'd0)
            begin
                res_reg.press <= '1;
            end
            else
            begin
                res_reg.press <= r_reg[31:0];
            end
            res_reg.tc     <= side_reg[7].tc;
            res_reg.tf     <= side_reg[7].tf;
            res_reg.hum    <= side_reg[7].hum;
            res_reg.pvalid <= side_reg[7].pvalid;
        end
    end

    assign out_valid = vld_reg[8];
    assign out_data  = res_reg;

endmodule

// File: rtl/esc_checker.sv
// Port-level checks of the compensation core, attached by bind.
`include "assert_macros.svh"

module esc_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         s_axis_tready,
    input logic                         m_axis_tvalid,
    input logic                         m_axis_tready,
    input logic [esc_pkg::M_DATA_W-1:0] m_axis_tdata,
    input logic [0:0]                   m_axis_tuser
);

    // A stalled result holds
    `ESC_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // Input side opens exactly when the result register can move
    `ESC_ASSERT_IMPL(a_ready_rule, clk, rst_n, 1'b1, s_axis_tready == (!m_axis_tvalid || m_axis_tready))

    // Invalid pressure reads as zero
    `ESC_ASSERT_IMPL(a_press_zero, clk, rst_n, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata[95:64] == 32'd0)

    // Humidity stays within 0 to 100 percent and padding stays clear
    `ESC_ASSERT_IMPL(a_hum_range, clk, rst_n, m_axis_tvalid, (m_axis_tdata[112:96] <= 17'd102400) && (m_axis_tdata[119:113] == 7'd0))

endmodule

bind env_sensor_compensation_core esc_checker u_esc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// File: sim/testbench.sv
// Self-checking testbench of the environmental sensor compensation core.
`timescale 1ns / 100ps

module testbench;

    localparam int CLK_PERIOD  = 20;
    localparam int LATENCY     = 87;
    localparam int STALL_LIMIT = 3000;
    // Indexes past the register list; writes there must be ignored
    localparam logic [esc_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [esc_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [15:0] hum;
        logic [19:0] temp;
        logic [19:0] press;
    } raw_triple_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [esc_pkg::S_DATA_W-1:0]   s_axis_tdata = '0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [esc_pkg::M_DATA_W-1:0]   m_axis_tdata;
    logic [0:0]                     m_axis_tuser;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [esc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [esc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    raw_triple_t          pending_triples[$];
    esc_pkg::esc_result_t expected_results[$];
    esc_pkg::esc_coef_t   coef = '0;
    logic        in_xfer = 1'b0;
    int          send_gap = 0;
    int          take_gap = 0;
    bit          burst_send = 1'b0;
    bit          burst_take = 1'b0;
    int          idle_cycles = 0;
    int          n_errors = 0;
    int          n_results = 0;
    int          n_no_press = 0;
    int          n_press_sat = 0;
    int          n_cfg_writes = 0;

    env_sensor_compensation_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Generate clock and hold reset at the start of the run
    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // Pick an idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(4, 40);
    endfunction

    // Compute the compensated result of one raw triple with the given coefficients
    function automatic esc_pkg::esc_result_t compensate(raw_triple_t raw,
                                                        esc_pkg::esc_coef_t c);
        esc_pkg::esc_result_t r;
        logic signed [31:0] t1, t2, t3, d1, d2, ta, tb, tf, m, q;
        logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic signed [63:0] v1, v2, den, num, p, ps, e1, e2;
        logic signed [31:0] h1, h2, h3, h4, h5, h6, hv, x, y, w, a, b;

        // temperature, 32-bit path
        t1 = {16'b0, c.temp[15:0]};
        t2 = 32'($signed(c.temp[31:16]));
        t3 = 32'($signed(c.temp[47:32]));
        d1 = {15'b0, raw.temp[19:3]};
        d1 = d1 - (t1 <<< 1);
        m  = d1 * t2;
        ta = m >>> 11;
        d2 = {16'b0, raw.temp[19:4]};
        d2 = d2 - t1;
        q  = d2 * d2;
        q  = q >>> 12;
        q  = q * t3;
        tb = q >>> 14;
        tf = ta + tb;
        m  = tf * 32'sd5 + 32'sd128;
        r.tc = m >>> 8;
        r.tf = tf;

        // pressure, 64-bit path
        p1 = {48'b0, c.press_lo[15:0]};
        p2 = 64'($signed(c.press_lo[31:16]));
        p3 = 64'($signed(c.press_lo[47:32]));
        p4 = 64'($signed(c.press_lo[63:48]));
        p5 = 64'($signed(c.press_hi[15:0]));
        p6 = 64'($signed(c.press_hi[31:16]));
        p7 = 64'($signed(c.press_hi[47:32]));
        p8 = 64'($signed(c.press_hi[63:48]));
        p9 = 64'($signed(c.press_nine));
        v1 = 64'(tf);
        v1 = v1 - 64'sd128000;
        v2 = v1 * v1 * p6 + ((v1 * p5) <<< 17) + (p4 <<< 35);
        den = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
        den = ((64'sh0000_8000_0000_0000 + den) * p1) >>> 33;
        r.press  = '0;
        r.pvalid = 1'b0;
        if (den != 0)
        begin
            p   = 64'sd1048576 - {44'b0, raw.press};
            num = ((p <<< 31) - v2) * 64'sd3125;
            if (num == 64'sh8000_0000_0000_0000 && den == -64'sd1)
                p = num;
            else
                p = num / den;
            ps = p >>> 13;
            e1 = (p9 * ps * ps) >>> 25;
            e2 = (p8 * p) >>> 19;
            p  = ((p + e1 + e2) >>> 8) + (p7 <<< 4);
            if (p < 0)
                r.press = '0;
            else if (p > 64'sh0000_0000_FFFF_FFFF)
                r.press = 32'hFFFF_FFFF;
            else
                r.press = p[31:0];
            r.pvalid = 1'b1;
        end

        // humidity, 32-bit path
        h1 = {24'b0, c.hum_a[7:0]};
        h2 = 32'($signed(c.hum_a[23:8]));
        h3 = {24'b0, c.hum_a[31:24]};
        h4 = 32'($signed(c.hum_b[11:0]));
        h5 = 32'($signed(c.hum_b[23:12]));
        h6 = 32'($signed(c.hum_b[31:24]));
        hv = tf - 32'sd76800;
        x  = {16'b0, raw.hum};
        w  = h5 * hv;
        x  = (x <<< 14) - (h4 <<< 20) - w + 32'sd16384;
        x  = x >>> 15;
        y  = hv * h6;
        y  = y >>> 10;
        w  = hv * h3;
        w  = (w >>> 11) + 32'sd32768;
        y  = y * w;
        y  = y >>> 10;
        y  = (y + 32'sd2097152) * h2 + 32'sd8192;
        y  = y >>> 14;
        w  = x * y;
        a  = w >>> 15;
        b  = a * a;
        b  = b >>> 7;
        b  = b * h1;
        b  = b >>> 4;
        w  = w - b;
        if (w < 0)
            w = 0;
        else if (w > $signed(esc_pkg::HUM_MAX))
            w = esc_pkg::HUM_MAX;
        r.hum = w[28:12];
        return r;
    endfunction

    // Input driver: hold a pending transfer, otherwise idle or load the next triple
    always @(negedge clk)
    begin
        if ($urandom_range(0, 299) == 0)
            burst_send <= ~burst_send;
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else if (!s_axis_tvalid || in_xfer)
        begin
            if (send_gap > 0)
            begin
                send_gap      <= send_gap - 1;
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_triples.size() > 0)
            begin
                s_axis_tdata  <= pending_triples.pop_front();
                s_axis_tvalid <= 1'b1;
                send_gap      <= burst_send ? 0 : pick_gap();
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Output stall driver
    always @(negedge clk)
    begin
        if ($urandom_range(0, 299) == 0)
            burst_take <= ~burst_take;
        if (burst_take)
            m_axis_tready <= 1'b1;
        else if (take_gap > 0)
        begin
            take_gap      <= take_gap - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            take_gap      <= pick_gap();
        end
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        n_errors++;
    endtask

    // Monitor: predict accepted inputs, check accepted results
    always @(posedge clk)
    begin
        esc_pkg::esc_result_t want;
        in_xfer <= s_axis_tvalid && s_axis_tready;
        if (rst_n && s_axis_tvalid && s_axis_tready)
            expected_results.push_back(compensate(raw_triple_t'(s_axis_tdata), coef));
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            n_results++;
            if (expected_results.size() == 0)
            begin
                $display("%0t: result with nothing expected", $time);
                n_errors++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (!want.pvalid)
                    n_no_press++;
                if (want.press == 32'hFFFF_FFFF)
                    n_press_sat++;
                if (m_axis_tdata[31:0] !== want.tc)
                    report_mismatch("temperature_centi", 64'(m_axis_tdata[31:0]),
                                    64'(want.tc));
                if (m_axis_tdata[63:32] !== want.tf)
                    report_mismatch("fine_temperature", 64'(m_axis_tdata[63:32]),
                                    64'(want.tf));
                if (m_axis_tdata[95:64] !== want.press)
                    report_mismatch("pressure_q24_8", 64'(m_axis_tdata[95:64]),
                                    64'(want.press));
                if (m_axis_tdata[112:96] !== want.hum)
                    report_mismatch("humidity_q22_10", 64'(m_axis_tdata[112:96]),
                                    64'(want.hum));
                if (m_axis_tdata[119:113] !== 7'b0)
                    report_mismatch("tdata padding", 64'(m_axis_tdata[119:113]), 64'd0);
                if (m_axis_tuser[0] !== want.pvalid)
                    report_mismatch("pressure_valid", 64'(m_axis_tuser[0]),
                                    64'(want.pvalid));
            end
        end
    end

    // Watchdog: end the run when no transfer of any kind happens for too long
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready) || !rst_n)
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t: timeout, %0d results outstanding", $time,
                     expected_results.size());
            $display("testbench: done, errors");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Write one register and mirror it in the predictor copy
    task automatic write_reg(input logic [esc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [63:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (esc_pkg::cfg_reg_t'(idx))
            esc_pkg::REG_TEMP:       coef.temp       = value[47:0];
            esc_pkg::REG_PRESS_LO:   coef.press_lo   = value;
            esc_pkg::REG_PRESS_HI:   coef.press_hi   = value;
            esc_pkg::REG_PRESS_NINE: coef.press_nine = value[15:0];
            esc_pkg::REG_HUM_A:      coef.hum_a      = value[31:0];
            esc_pkg::REG_HUM_B:      coef.hum_b      = value[31:0];
            default:                 ;
        endcase
        n_cfg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_coefs(input esc_pkg::esc_coef_t c);
        write_reg(esc_pkg::REG_TEMP, {16'b0, c.temp});
        write_reg(esc_pkg::REG_PRESS_LO, c.press_lo);
        write_reg(esc_pkg::REG_PRESS_HI, c.press_hi);
        write_reg(esc_pkg::REG_PRESS_NINE, {48'b0, c.press_nine});
        write_reg(esc_pkg::REG_HUM_A, {32'b0, c.hum_a});
        write_reg(esc_pkg::REG_HUM_B, {32'b0, c.hum_b});
    endtask

    // Wait until every expected result has come and the pipeline has drained
    task automatic drain();
        while (pending_triples.size() > 0 || s_axis_tvalid || expected_results.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    task automatic queue_random(input int count);
        raw_triple_t t;
        repeat (count)
        begin
            t.press = 20'($urandom_range(0, 20'hFFFFF));
            t.temp  = 20'($urandom_range(0, 20'hFFFFF));
            t.hum   = 16'($urandom_range(0, 16'hFFFF));
            // most triples near typical converter codes, the rest full range
            if ($urandom_range(0, 3) != 0)
            begin
                t.press = 20'($urandom_range(250000, 600000));
                t.temp  = 20'($urandom_range(400000, 600000));
                t.hum   = 16'($urandom_range(20000, 45000));
            end
            pending_triples.push_back(t);
        end
    endtask

    task automatic queue_directed();
        raw_triple_t t;
        logic [19:0] corner[6];
        corner = '{20'h00000, 20'hFFFFF, 20'hAAAAA, 20'h55555, 20'h80000, 20'h7FFFF};
        for (int i = 0; i < 6; i++)
        begin
            t.press = corner[i];
            t.temp  = corner[i];
            t.hum   = corner[i][15:0];
            pending_triples.push_back(t);
            t.press = corner[5 - i];
            t.temp  = corner[(i + 2) % 6];
            t.hum   = corner[(i + 3) % 6][19:4];
            pending_triples.push_back(t);
        end
        t = '{hum: 16'd30000, temp: 20'd519888, press: 20'd415148};
        pending_triples.push_back(t);
    endtask

    // Stimulus: phases of coefficient settings, each with directed triples, random triples or both
    initial
    begin
        esc_pkg::esc_coef_t c;
        esc_pkg::esc_coef_t typical;
        typical.temp       = {16'hFC18, 16'd26435, 16'd27504};
        typical.press_lo   = {16'd2855, 16'd3024, -16'sd10685, 16'd36477};
        typical.press_hi   = {-16'sd14600, 16'd15500, -16'sd7, 16'd140};
        typical.press_nine = 16'd6000;
        typical.hum_a      = {8'd0, 16'd362, 8'd75};
        typical.hum_b      = {8'd30, 12'd50, 12'd313};

        wait (rst_n);
        @(posedge clk);

        // reset coefficients: zero pressure divisor everywhere
        queue_directed();
        drain();

        // typical factory calibration, plus writes to unused indexes
        load_coefs(typical);
        write_reg(REG_SPARE_LO, {64{1'b1}});
        write_reg(REG_SPARE_HI, 64'h5A5A_5A5A_A5A5_A5A5);
        queue_directed();
        queue_random(520);
        drain();

        // all ones, then most negative / most positive signed coefficients
        load_coefs('1);
        queue_directed();
        queue_random(80);
        drain();
        c.temp       = {16'h8000, 16'h8000, 16'hFFFF};
        c.press_lo   = {16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF};
        c.press_hi   = {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF};
        c.press_nine = 16'h8000;
        c.hum_a      = {8'hFF, 16'h8000, 8'hFF};
        c.hum_b      = {8'h7F, 12'h800, 12'h7FF};
        load_coefs(c);
        queue_directed();
        queue_random(80);
        drain();

        // typical settings with one group of coefficients randomized at a time
        for (int ph = 0; ph < 6; ph++)
        begin
            c = typical;
            case (ph % 3)
                0: c.temp = 48'({$urandom, $urandom});
                1: {c.press_lo, c.press_hi, c.press_nine} = 144'({$urandom, $urandom,
                       $urandom, $urandom, $urandom});
                default: {c.hum_a, c.hum_b} = {$urandom, $urandom};
            endcase
            load_coefs(c);
            queue_random(100);
            drain();
        end

        // fully random coefficients
        for (int ph = 0; ph < 2; ph++)
        begin
            c = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom};
            load_coefs(c);
            queue_random(60);
            drain();
        end

        $display("checked %0d results over %0d register writes", n_results, n_cfg_writes);
        $display("%0d without pressure, %0d with pressure saturated high",
                 n_no_press, n_press_sat);
        if (n_errors == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/esc_pkg.sv
rtl/esc_mul64.sv
rtl/esc_front.sv
rtl/esc_div.sv
rtl/esc_post.sv
rtl/env_sensor_compensation_core.sv
rtl/esc_checker.sv
sim/testbench.sv
